### design/idiv_pkg.sv
// ----------------------------------------------------------------------------
// Integer divider package
// Widths, operation codes and the types shared by the divider modules.
// ----------------------------------------------------------------------------
package idiv_pkg;

   // Operand and result widths.
   localparam int DATA_W   = 64;
   localparam int NARROW_W = 32;
   localparam int OP_W     = 2;
   localparam int CNT_W    = 6;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_UQUO = 2'd0;
   localparam logic [OP_W-1:0] OP_UREM = 2'd1;
   localparam logic [OP_W-1:0] OP_SQUO = 2'd2;
   localparam logic [OP_W-1:0] OP_SREM = 2'd3;

   // Iteration counts, loaded as the index of the top bit.
   localparam logic [CNT_W-1:0] TOP_WIDE   = CNT_W'(DATA_W - 1);
   localparam logic [CNT_W-1:0] TOP_NARROW = CNT_W'(NARROW_W - 1);

   // Operand of one restoring step.
   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic              num_bit;
      logic [DATA_W-1:0] den;
      logic              wide;
   } step_in_type;

   // Outcome of one restoring step.
   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic              quo_bit;
   } step_out_type;

   // Mask that keeps the bits of the selected operand width.
   function automatic logic [DATA_W-1:0] width_mask(input logic wide);
      return wide ? {DATA_W{1'b1}} : {{(DATA_W-NARROW_W){1'b0}}, {NARROW_W{1'b1}}};
   endfunction

endpackage

### design/idiv_if.sv
// ----------------------------------------------------------------------------
// Integer divider channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: operation, width select and both operands.
interface idiv_req_if import idiv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic                wide;
   logic [DATA_W-1:0]   dividend;
   logic [DATA_W-1:0]   divisor;

   modport source (output valid, operation, wide, dividend, divisor, input ready);
   modport sink   (input valid, operation, wide, dividend, divisor, output ready);
endinterface

// Response channel: quotient or remainder.
interface idiv_rsp_if import idiv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

### design/idiv_step.sv
// ----------------------------------------------------------------------------
// Integer divider restoring step
// Shifts one dividend bit into the partial remainder and subtracts the
// divisor when it fits, giving one quotient bit.
// ----------------------------------------------------------------------------
module idiv_step import idiv_pkg::*; (
   input  step_in_type  step_in,
   output step_out_type step_out
);

   logic [DATA_W-1:0] mask;
   logic              carry;
   logic [DATA_W-1:0] shifted;
   logic [DATA_W-1:0] diff;
   logic              fits;

   // The bit shifted out of the top acts as the extra remainder bit.
   always_comb begin
      mask    = width_mask(step_in.wide);
      carry   = step_in.wide ? step_in.rem[DATA_W-1] : step_in.rem[NARROW_W-1];
      shifted = {step_in.rem[DATA_W-2:0], step_in.num_bit} & mask;
      diff    = (shifted - step_in.den) & mask;
      fits    = carry || (shifted >= step_in.den);
      step_out.rem     = fits ? diff : shifted;
      step_out.quo_bit = fits;
   end

endmodule

### design/integer_divider_signed_unsigned.sv
// ----------------------------------------------------------------------------
// Signed and unsigned integer divider
// Radix-2 restoring division at 32 or 64 bits, returning the quotient or
// the remainder of one request.
// ----------------------------------------------------------------------------
// From acceptance to a valid response, a request passes through ST_PREP,
// which takes the operand magnitudes, ST_RUN, which produces one quotient
// bit per cycle through the single shared subtract-and-compare step, and
// ST_FIX, which fixes the sign. The request side is ready only while no
// division is in progress; a finished response waits in its output
// register, so the next request can be accepted while it does. If the
// previous response is still held when a division finishes, the sign fix
// waits until that response is taken. A zero divisor gives 0. Signed
// operations divide magnitudes; the quotient is negated when the operand
// signs differ and the remainder takes the sign of the dividend. In 32-bit
// mode the upper 32 result bits are zero.
module integer_divider_signed_unsigned import idiv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   idiv_req_if.sink    req_ch,
   idiv_rsp_if.source  rsp_ch
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_FIX  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic              wide_ff, wide_in;
   logic [DATA_W-1:0] num_ff, num_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_q_ff, neg_q_in;
   logic              neg_r_ff, neg_r_in;
   logic              dz_ff, dz_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] result_ff, result_in;

   logic [DATA_W-1:0] mask;
   logic              sign_a;
   logic              sign_b;
   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;
   logic [DATA_W-1:0] fix_val;
   logic [DATA_W-1:0] fix_res;
   logic              fix_load;
   step_in_type       step_in;
   step_out_type      step_out;

   // Shared restoring step.
   idiv_step u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = result_ff;

   // Operand signs, magnitudes and the final sign correction.
   always_comb begin
      mask    = width_mask(wide_ff);
      sign_a  = op_ff[1] & (wide_ff ? num_ff[DATA_W-1] : num_ff[NARROW_W-1]);
      sign_b  = op_ff[1] & (wide_ff ? den_ff[DATA_W-1] : den_ff[NARROW_W-1]);
      mag_a   = sign_a ? ((DATA_W'(0) - num_ff) & mask) : num_ff;
      mag_b   = sign_b ? ((DATA_W'(0) - den_ff) & mask) : den_ff;
      fix_val = (op_ff inside {OP_UREM, OP_SREM}) ? rem_ff : quo_ff;
      if ((op_ff == OP_SREM && neg_r_ff) || (op_ff == OP_SQUO && neg_q_ff)) begin
         fix_res = (DATA_W'(0) - fix_val) & mask;
      end else begin
         fix_res = fix_val & mask;
      end
      if (dz_ff) begin
         fix_res = '0;
      end
      fix_load = (state_ff == ST_FIX) && (!rsp_valid_ff || rsp_ch.ready);
   end

   // Step operands come from the working registers.
   always_comb begin
      step_in.rem     = rem_ff;
      step_in.num_bit = num_ff[DATA_W-1];
      step_in.den     = den_ff;
      step_in.wide    = wide_ff;
   end

   // Sequencer and working registers.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      wide_in      = wide_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      dz_in        = dz_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               wide_in  = req_ch.wide;
               num_in   = req_ch.dividend & width_mask(req_ch.wide);
               den_in   = req_ch.divisor & width_mask(req_ch.wide);
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // Left-align the dividend so its bits leave from the top.
            num_in   = wide_ff ? mag_a : {mag_a[NARROW_W-1:0], {(DATA_W-NARROW_W){1'b0}}};
            den_in   = mag_b;
            neg_q_in = sign_a ^ sign_b;
            neg_r_in = sign_a;
            dz_in    = (den_ff == '0);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = wide_ff ? TOP_WIDE : TOP_NARROW;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rem_in = step_out.rem;
            quo_in = {quo_ff[DATA_W-2:0], step_out.quo_bit};
            num_in = {num_ff[DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (fix_load) begin
               result_in    = fix_res;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      wide_ff   <= wide_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      dz_ff     <= dz_in;
      result_ff <= result_in;
   end

endmodule

### dv/integer_divider_signed_unsigned_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer divider testbench
// Sends directed and random division requests through the request channel.
// Each accepted transaction is predicted with the native divide and modulo
// operators on magnitudes. Every response is checked in order against that
// prediction, while both channels stall at random for the first two thirds.
// ----------------------------------------------------------------------------
module integer_divider_signed_unsigned_tb import idiv_pkg::*; ;

   localparam int RANDOM_REQUESTS = 550;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int REPORT_LIMIT    = 10;

   // One division request as it travels over the request channel.
   typedef struct {
      logic [OP_W-1:0]   operation;
      logic              wide;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   idiv_req_if req_bus ();
   idiv_rsp_if rsp_bus ();

   integer_divider_signed_unsigned u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source)
   );

   div_request_type   division_requests[$];
   logic [DATA_W-1:0] division_results[$];
   div_request_type   next_req;
   int                total_requests;
   int                accepted_requests;
   int                error_count;
   int                stall_cycles;
   int                send_idle_pct;
   int                recv_idle_pct;
   logic              req_taken;

   always #4 clock = ~clock;

   // Quotient or remainder of one request, masked to the selected width.
   function automatic logic [DATA_W-1:0] compute_division(
      input logic [OP_W-1:0]   op,
      input logic              wide,
      input logic [DATA_W-1:0] dividend,
      input logic [DATA_W-1:0] divisor
   );
      logic [DATA_W-1:0] keep;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] res;
      logic              num_neg;
      logic              den_neg;
      keep    = wide ? {DATA_W{1'b1}} : 64'h0000_0000_FFFF_FFFF;
      num     = dividend & keep;
      den     = divisor & keep;
      num_neg = wide ? num[DATA_W-1] : num[NARROW_W-1];
      den_neg = wide ? den[DATA_W-1] : den[NARROW_W-1];
      // Signed operations work on magnitudes.
      if (op == OP_SQUO || op == OP_SREM) begin
         if (num_neg) num = (64'd0 - num) & keep;
         if (den_neg) den = (64'd0 - den) & keep;
      end
      // A zero divisor gives zero for both quotient and remainder.
      if (den == 64'd0) begin
         quo = 64'd0;
         rem = 64'd0;
      end else begin
         quo = num / den;
         rem = num % den;
      end
      case (op)
         OP_UQUO: res = quo;
         OP_UREM: res = rem;
         OP_SQUO: res = (num_neg != den_neg) ? (64'd0 - quo) : quo;
         default: res = num_neg ? (64'd0 - rem) : rem;
      endcase
      return res & keep;
   endfunction

   // Operand pattern with a bias toward small, negative and boundary values.
   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: v = 64'($urandom_range(0, 15));
         1: v = 64'd0 - 64'($urandom_range(1, 15));
         2: v = v >> $urandom_range(1, 62);
         3: v = {v[63:32], 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))};
         4: begin
            case ($urandom_range(0, 6))
               0: v = 64'd0;
               1: v = 64'd1;
               2: v = {DATA_W{1'b1}};
               3: v = 64'h8000_0000_0000_0000;
               4: v = 64'h7FFF_FFFF_FFFF_FFFF;
               5: v = {v[63:32], 32'h8000_0000};
               default: v = {v[63:32], 32'hFFFF_FFFF};
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_request(
      input logic [OP_W-1:0]   op,
      input logic              wide,
      input logic [DATA_W-1:0] dividend,
      input logic [DATA_W-1:0] divisor
   );
      div_request_type r;
      r.operation = op;
      r.wide      = wide;
      r.dividend  = dividend;
      r.divisor   = divisor;
      division_requests.push_back(r);
   endtask

   // Stall rates: sender light and receiver heavy, then swapped, then none.
   always_comb begin
      if (accepted_requests < total_requests / 3) begin
         send_idle_pct = 9;
         recv_idle_pct = 84;
      end else if (accepted_requests < (2 * total_requests) / 3) begin
         send_idle_pct = 84;
         recv_idle_pct = 9;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // Request driver: holds a transaction until it is taken, then may idle.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (division_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = division_requests.pop_front();
            req_bus.operation <= next_req.operation;
            req_bus.wide      <= next_req.wide;
            req_bus.dividend  <= next_req.dividend;
            req_bus.divisor   <= next_req.divisor;
            req_bus.valid     <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready with random back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Request monitor: predicts the result of every accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            division_results.push_back(compute_division(req_bus.operation, req_bus.wide,
                                                        req_bus.dividend, req_bus.divisor));
            accepted_requests <= accepted_requests + 1;
         end
      end
   end

   // Response monitor: compares each transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (division_results.size() == 0) begin
            if (error_count < REPORT_LIMIT)
               $display("%0t: unexpected response result=%h", $realtime, rsp_bus.result);
            error_count <= error_count + 1;
         end else begin
            if (rsp_bus.result !== division_results[0]) begin
               if (error_count < REPORT_LIMIT)
                  $display("%0t: result mismatch expected=%h actual=%h",
                           $realtime, division_results[0], rsp_bus.result);
               error_count <= error_count + 1;
            end
            void'(division_results.pop_front());
         end
      end
   end

   // Watchdog on cycles without any transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      // Division by zero for every operation at both widths.
      add_request(OP_UQUO, 1'b1, 64'hDEAD_BEEF_0123_4567, 64'd0);
      add_request(OP_UREM, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      add_request(OP_SQUO, 1'b1, 64'h8000_0000_0000_0000, 64'd0);
      add_request(OP_SREM, 1'b1, 64'hFFFF_FFFF_FFFF_FFF9, 64'd0);
      add_request(OP_UQUO, 1'b0, 64'h0000_0000_1234_5678, 64'hFFFF_FFFF_0000_0000);
      add_request(OP_UREM, 1'b0, 64'h5555_5555_FFFF_FFFF, 64'hAAAA_AAAA_0000_0000);
      add_request(OP_SQUO, 1'b0, 64'h0000_0000_8000_0000, 64'h1234_5678_0000_0000);
      add_request(OP_SREM, 1'b0, 64'hFFFF_FFFF_FFFF_FFF9, 64'h0000_0001_0000_0000);
      // Most negative value divided by minus one wraps.
      add_request(OP_SQUO, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      add_request(OP_SREM, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      add_request(OP_SQUO, 1'b0, 64'hA5A5_A5A5_8000_0000, 64'h0F0F_0F0F_FFFF_FFFF);
      add_request(OP_SREM, 1'b0, 64'h5A5A_5A5A_8000_0000, 64'h0000_0000_FFFF_FFFF);
      // Unsigned divisors with the top bit set.
      add_request(OP_UQUO, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001);
      add_request(OP_UREM, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001);
      add_request(OP_UQUO, 1'b0, 64'h1111_1111_FFFF_FFFF, 64'h2222_2222_8000_0000);
      add_request(OP_UREM, 1'b0, 64'h3333_3333_FFFF_FFFF, 64'h4444_4444_8000_0000);
      add_request(OP_UQUO, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      add_request(OP_UREM, 1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      // Ordinary signed cases with each sign combination.
      add_request(OP_SQUO, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
      add_request(OP_SQUO, 1'b1, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
      add_request(OP_SREM, 1'b1, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
      add_request(OP_SREM, 1'b0, 64'h0000_0000_0000_0007, 64'h0000_0000_FFFF_FFFE);
      add_request(OP_SQUO, 1'b0, 64'hFFFF_FFFF_FFFF_FFF9, 64'h0000_0000_FFFF_FFFE);

      // Random requests over all operations and both widths.
      repeat (RANDOM_REQUESTS)
         add_request(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     pick_operand(), pick_operand());
      total_requests = division_requests.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (division_requests.size() != 0 || req_bus.valid) @(negedge clock);
      while (division_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
